// File: design/assert_macros.svh
// Assertion macros for the RTL of the WAVE parser, used by the core file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, live during reset as well.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

// File: design/rwp_pkg.sv
// Shared types, constants and field checks of the WAVE parser.
package rwp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] RESET_SAMPLE_RATE = 32'd32000;
  localparam logic [31:0] RESET_BYTE_RATE   = 32'd64000;
  localparam logic [23:0] RESET_MAX_SAMPLES = 24'd320000;

  // Configuration register indexes
  localparam logic [1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [1:0] CFG_BYTE_RATE   = 2'd1;
  localparam logic [1:0] CFG_MAX_SAMPLES = 2'd2;

  // Byte positions in the file header
  localparam logic [31:0] POS_RIFF_END = 32'd3;
  localparam logic [31:0] POS_SIZE_END = 32'd7;
  localparam logic [31:0] POS_WAVE_END = 32'd11;

  // Chunk header byte positions
  localparam logic [2:0] HDR_TAG_END = 3'd3;
  localparam logic [2:0] HDR_LEN_END = 3'd7;

  // Last byte of each checked fmt field
  localparam logic [3:0] FMT_POS_FORMAT   = 4'd1;
  localparam logic [3:0] FMT_POS_CHANNELS = 4'd3;
  localparam logic [3:0] FMT_POS_RATE     = 4'd7;
  localparam logic [3:0] FMT_POS_BYTERATE = 4'd11;
  localparam logic [3:0] FMT_POS_ALIGN    = 4'd13;
  localparam logic [3:0] FMT_POS_BITS     = 4'd15;

  localparam logic [31:0] FMT_MIN_LEN = 32'd16;

  typedef enum logic [1:0] {
    PH_FILE,
    PH_CHDR,
    PH_BODY,
    PH_PAD
  } phase_t;

  typedef struct packed {
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [23:0] max_samples;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               sample_valid;
    logic               done;
    logic               rejected;
  } res_t;

  // True when the fmt field ending at pos does not match; acc holds the last four bytes.
  function automatic logic fmt_field_bad(input logic [3:0]  pos,
                                         input logic [31:0] acc,
                                         input logic [31:0] sample_rate,
                                         input logic [31:0] byte_rate);
    logic bad;
    bad = 1'b0;
    unique case (pos)
      FMT_POS_FORMAT:   bad = (acc[31:16] != 16'd1);
      FMT_POS_CHANNELS: bad = (acc[31:16] != 16'd1);
      FMT_POS_RATE:     bad = (acc != sample_rate);
      FMT_POS_BYTERATE: bad = (acc != byte_rate);
      FMT_POS_ALIGN:    bad = (acc[31:16] != 16'd2);
      FMT_POS_BITS:     bad = (acc[31:16] != 16'd16);
      default:          bad = 1'b0;
    endcase
    return bad;
  endfunction

endpackage

// File: design/rwp_out_reg.sv
// Result register of the WAVE parser, holds one transaction until taken.
module rwp_out_reg import rwp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic res_push,
  input  res_t res,
  output logic out_free,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_res <= res;
    end
  end

endmodule

// File: design/rwp_parse.sv
// Input register and byte-wise RIFF/WAVE parse state with its next-state logic.
module rwp_parse import rwp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_value,
  input  logic       last_byte,
  input  cfg_t       cfg,
  input  logic       out_free,
  output logic       res_push,
  output res_t       res
);

  // input register
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_last;

  // parse state
  logic [31:0] byte_count;
  logic [31:0] file_left;   // declared size minus bytes taken after byte 7, once past byte 7
  phase_t      phase;
  logic [2:0]  hdr_cnt;
  logic [31:0] chunk_remaining;
  logic [4:0]  body_pos;    // saturates at 16, only the fmt fields need it
  logic        tag_fmt;
  logic        tag_data;
  logic [31:0] acc;
  logic [7:0]  low_byte_hold;
  logic        format_seen;
  logic        data_seen;
  logic        pad_pending;
  logic        error_latched;

  // stepped values before the end-of-file clear
  logic [31:0] byte_count_next;
  logic [31:0] file_left_next;
  phase_t      phase_next;
  logic [2:0]  hdr_cnt_next;
  logic [31:0] chunk_remaining_next;
  logic [4:0]  body_pos_next;
  logic        tag_fmt_next;
  logic        tag_data_next;
  logic [31:0] acc_next;
  logic [7:0]  low_byte_hold_next;
  logic        format_seen_next;
  logic        data_seen_next;
  logic        pad_pending_next;
  logic        error_latched_next;

  logic        advance;
  logic        live;
  logic        emit_sample;
  logic [31:0] acc_shift;
  logic [31:0] left_m1;

  assign acc_shift = {hold_byte, acc[31:8]};
  assign left_m1   = file_left - 32'd1;
  assign live      = !error_latched && (byte_count != '1) &&
                     !((|byte_count[31:3]) && (file_left == 32'd0));

  assign emit_sample = live && (phase == PH_BODY) && tag_data && chunk_remaining[0];

  assign advance  = hold_valid && (!(emit_sample || hold_last) || out_free);
  assign in_ready = !hold_valid || advance;
  assign res_push = advance && (emit_sample || hold_last);

  // next state of the parser for the byte in the input register
  always_comb begin
    byte_count_next      = byte_count;
    file_left_next       = file_left;
    phase_next           = phase;
    hdr_cnt_next         = hdr_cnt;
    chunk_remaining_next = chunk_remaining;
    body_pos_next        = body_pos;
    tag_fmt_next         = tag_fmt;
    tag_data_next        = tag_data;
    acc_next             = acc;
    low_byte_hold_next   = low_byte_hold;
    format_seen_next     = format_seen;
    data_seen_next       = data_seen;
    pad_pending_next     = pad_pending;
    error_latched_next   = error_latched;

    if (!error_latched) begin
      if (!live) begin
        error_latched_next = 1'b1;
      end else begin
        acc_next        = acc_shift;
        byte_count_next = byte_count + 32'd1;
        if (|byte_count[31:3]) begin
          file_left_next = file_left - 32'd1;
        end
        unique case (phase)
          PH_FILE: begin
            if (byte_count == POS_RIFF_END && acc_shift != TAG_RIFF) begin
              error_latched_next = 1'b1;
            end else if (byte_count == POS_SIZE_END) begin
              file_left_next = acc_shift;
            end else if (byte_count == POS_WAVE_END) begin
              if (acc_shift != TAG_WAVE) begin
                error_latched_next = 1'b1;
              end else begin
                phase_next   = PH_CHDR;
                hdr_cnt_next = 3'd0;
              end
            end
          end
          PH_CHDR: begin
            hdr_cnt_next = hdr_cnt + 3'd1;
            if (hdr_cnt == HDR_TAG_END) begin
              tag_fmt_next  = (acc_shift == TAG_FMT);
              tag_data_next = (acc_shift == TAG_DATA);
            end else if (hdr_cnt == HDR_LEN_END) begin
              // length in acc_shift; must fit in what is left, pad byte included
              if (acc_shift > left_m1 || (acc_shift[0] && acc_shift == left_m1)) begin
                error_latched_next = 1'b1;
              end else if (tag_fmt && (format_seen || acc_shift < FMT_MIN_LEN)) begin
                error_latched_next = 1'b1;
              end else if (tag_data && (data_seen || acc_shift == 32'd0 || acc_shift[0] ||
                           acc_shift[31:1] > {7'd0, cfg.max_samples})) begin
                error_latched_next = 1'b1;
              end else begin
                if (tag_fmt) begin
                  format_seen_next = 1'b1;
                end
                if (tag_data) begin
                  data_seen_next = 1'b1;
                end
                pad_pending_next     = acc_shift[0];
                chunk_remaining_next = acc_shift;
                body_pos_next        = 5'd0;
                if (acc_shift == 32'd0) begin
                  phase_next   = PH_CHDR;
                  hdr_cnt_next = 3'd0;
                end else begin
                  phase_next = PH_BODY;
                end
              end
            end
          end
          PH_BODY: begin
            if (tag_fmt && !body_pos[4] &&
                fmt_field_bad(body_pos[3:0], acc_shift, cfg.sample_rate, cfg.byte_rate)) begin
              error_latched_next = 1'b1;
            end
            // data length is even, so an even remaining count is a low byte
            if (tag_data && !chunk_remaining[0]) begin
              low_byte_hold_next = hold_byte;
            end
            if (!body_pos[4]) begin
              body_pos_next = body_pos + 5'd1;
            end
            chunk_remaining_next = chunk_remaining - 32'd1;
            if (chunk_remaining == 32'd1) begin
              if (pad_pending) begin
                phase_next = PH_PAD;
              end else begin
                phase_next   = PH_CHDR;
                hdr_cnt_next = 3'd0;
              end
            end
          end
          PH_PAD: begin
            pad_pending_next = 1'b0;
            phase_next       = PH_CHDR;
            hdr_cnt_next     = 3'd0;
          end
          default: begin
            phase_next = PH_FILE;
          end
        endcase
      end
    end
  end

  // result for the byte in the input register
  always_comb begin
    res.sample_valid = emit_sample;
    res.sample       = emit_sample ? $signed({hold_byte, low_byte_hold}) : 16'sd0;
    res.done         = hold_last;
    res.rejected     = hold_last &&
                       (error_latched_next || phase_next != PH_CHDR ||
                        hdr_cnt_next != 3'd0 || file_left_next != 32'd0 ||
                        !format_seen_next || !data_seen_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= byte_value;
      hold_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && hold_last)) begin
      byte_count      <= 32'd0;
      file_left       <= 32'd0;
      phase           <= PH_FILE;
      hdr_cnt         <= 3'd0;
      chunk_remaining <= 32'd0;
      body_pos        <= 5'd0;
      tag_fmt         <= 1'b0;
      tag_data        <= 1'b0;
      acc             <= 32'd0;
      low_byte_hold   <= 8'd0;
      format_seen     <= 1'b0;
      data_seen       <= 1'b0;
      pad_pending     <= 1'b0;
      error_latched   <= 1'b0;
    end else if (advance) begin
      byte_count      <= byte_count_next;
      file_left       <= file_left_next;
      phase           <= phase_next;
      hdr_cnt         <= hdr_cnt_next;
      chunk_remaining <= chunk_remaining_next;
      body_pos        <= body_pos_next;
      tag_fmt         <= tag_fmt_next;
      tag_data        <= tag_data_next;
      acc             <= acc_next;
      low_byte_hold   <= low_byte_hold_next;
      format_seen     <= format_seen_next;
      data_seen       <= data_seen_next;
      pad_pending     <= pad_pending_next;
      error_latched   <= error_latched_next;
    end
  end

endmodule

// File: design/riff_wave_pcm_parser_core.sv
// RIFF/WAVE 16-bit mono PCM parser: one file byte per transaction in, samples and status out.
// Throughput: one byte per cycle while the result side keeps taking transactions.
// Path: an accepted byte is held in the input register, which feeds the result register;
//   its result is registered there and waits until the consumer takes it.
// Reset: rst (synchronous) empties both registers, restarts the parse and reloads the rates.
`include "assert_macros.svh"

module riff_wave_pcm_parser_core import rwp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // byte input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         byte_value,
  input  logic               last_byte,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample,
  output logic               sample_valid,
  output logic               done_res,
  output logic               rejected
);

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic res_push;
  logic out_free;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_rate <= RESET_SAMPLE_RATE;
      cfg.byte_rate   <= RESET_BYTE_RATE;
      cfg.max_samples <= RESET_MAX_SAMPLES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLE_RATE: cfg.sample_rate <= cfg_data;
        CFG_BYTE_RATE:   cfg.byte_rate   <= cfg_data;
        CFG_MAX_SAMPLES: cfg.max_samples <= cfg_data[23:0];
        default:         ;
      endcase
    end
  end

  // Parser: the byte sits in the input register while the running state
  // (header, chunk walk, fmt checks, sample assembly) works out its result.
  // A byte that yields no result moves on even while the output is full.
  rwp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .cfg        (cfg),
    .out_free   (out_free),
    .res_push   (res_push),
    .res        (res)
  );

  // Result register: holds a transaction until the consumer takes it.
  rwp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_push  (res_push),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign sample       = out_res.sample;
  assign sample_valid = out_res.sample_valid;
  assign done_res     = out_res.done;
  assign rejected     = out_res.rejected;

  // Rejection is only ever reported with done.
  `ASSERT_IMPL(a_rej_with_done, out_valid && rejected, done_res)
  // Every result carries a sample or the end of a file.
  `ASSERT_IMPL(a_res_not_empty, out_valid, sample_valid || done_res)
  // No sample means the sample field reads zero.
  `ASSERT_IMPL(a_sample_zero, out_valid && !sample_valid, sample == 16'sd0)
  // With the output empty, input is never stalled.
  `ASSERT_IMPL(a_ready_when_free, !out_valid, in_ready)
  // Both registers are empty straight after reset.
  `ASSERT_NEXT(a_reset_empty, rst, !out_valid && in_ready)

endmodule
